@@ sv/nsl_pkg.sv @@
// Shared types for the nearest symbol lookup block.
package nsl_pkg;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned SYM_W   = 10;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } item_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_EMIT
   } scan_state_type;

endpackage

@@ sv/nsl_queue.sv @@
// Two-entry queue between the front and back parts.
module nsl_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/nsl_front.sv @@
// Front part: takes requests and the count register, classifies items for the queue.
module nsl_front
   import nsl_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 1024,
   parameter int unsigned IDX_W       = 10,
   parameter int unsigned LIM_W       = 11,
   parameter int unsigned ITEM_W      = 1 + IDX_W + ADDR_W + LIM_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [SYM_W-1:0]   req_entry_index,
   input  logic [ADDR_W-1:0]  req_code_address,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_table_count,
   output logic               push_valid,
   input  logic               push_ready,
   output logic [ITEM_W-1:0]  push_data
);

   localparam int unsigned WIDE_W = IDX_W + SYM_W;

   logic [COUNT_W-1:0] table_count_ff, table_count_in;
   logic [WIDE_W-1:0]  index_wide;
   logic               index_ok;
   logic [LIM_W-1:0]   count_ext;
   logic [LIM_W-1:0]   limit;
   item_kind_type      kind;

   assign csr_ready = 1'b1;
   assign table_count_in = (csr_valid && csr_ready) ? csr_table_count : table_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_count_ff <= '0;
      end else begin
         table_count_ff <= table_count_in;
      end
   end

   // Saturate the scan length at the table depth
   assign count_ext = LIM_W'(table_count_ff);
   assign limit     = (count_ext > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : count_ext;

   assign index_wide = {{IDX_W{1'b0}}, req_entry_index};
   assign index_ok   = (index_wide < WIDE_W'(TABLE_DEPTH));
   assign kind       = (req_op == 1'b1) ? KIND_QUERY : KIND_LOAD;

   assign req_stall  = !push_ready;
   // Drop loads aimed beyond the table
   assign push_valid = req_valid && ((kind == KIND_QUERY) || index_ok);
   assign push_data  = {kind, index_wide[IDX_W-1:0], req_code_address, limit};

endmodule

@@ sv/nsl_back.sv @@
// Back part: symbol table memory, linear predecessor scan and result register.
module nsl_back
   import nsl_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 1024,
   parameter int unsigned IDX_W       = 10,
   parameter int unsigned LIM_W       = 11,
   parameter int unsigned ITEM_W      = 1 + IDX_W + ADDR_W + LIM_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  logic [ITEM_W-1:0] pop_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_found,
   output logic [SYM_W-1:0]  rsp_symbol_index,
   output logic [ADDR_W-1:0] rsp_symbol_start,
   output logic [ADDR_W-1:0] rsp_offset
);

   item_kind_type     item_kind;
   logic [IDX_W-1:0]  item_index;
   logic [ADDR_W-1:0] item_address;
   logic [LIM_W-1:0]  item_limit;

   scan_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [LIM_W-1:0]  limit_ff, limit_in;
   logic [ADDR_W-1:0] query_ff, query_in;
   logic [ADDR_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0] mem_rd_ff;
   logic [ADDR_W-1:0] table_mem [TABLE_DEPTH];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [SYM_W-1:0]  rsp_index_ff;
   logic [ADDR_W-1:0] rsp_start_ff;
   logic [ADDR_W-1:0] rsp_offset_ff;

   logic              out_free;
   logic              at_last;
   logic              pop_now, mem_we, scan_start, rd_en, emit;
   logic              hit;
   logic [IDX_W+SYM_W-1:0] best_idx_wide;

   assign {item_kind, item_index, item_address, item_limit} = pop_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign at_last  = (LIM_W'(ptr_ff) == (limit_ff - LIM_W'(1)));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid && (item_kind == KIND_QUERY)) begin
               state_in = (item_limit == '0) ? ST_EMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (at_last) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs
   always_comb begin
      pop_now    = 1'b0;
      rd_en      = 1'b0;
      emit       = 1'b0;
      case (state_ff)
         ST_IDLE: pop_now = pop_valid;
         ST_SCAN: rd_en   = 1'b1;
         ST_EMIT: emit    = out_free;
         default: begin
            pop_now = 1'b0;
         end
      endcase
      mem_we     = pop_now && (item_kind == KIND_LOAD);
      scan_start = pop_now && (item_kind == KIND_QUERY);
   end

   assign pop_ready = pop_now;

   // Strict greater-than keeps the lowest index holding the best address
   assign hit = rd_vld_ff && (mem_rd_ff <= query_ff) && (mem_rd_ff > best_ff);

   always_comb begin
      ptr_in      = ptr_ff;
      limit_in    = limit_ff;
      query_in    = query_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      rd_vld_in   = rd_en;
      rd_idx_in   = rd_en ? ptr_ff : rd_idx_ff;
      if (scan_start) begin
         ptr_in      = '0;
         limit_in    = item_limit;
         query_in    = item_address;
         best_in     = '0;
         best_idx_in = '0;
      end else begin
         if (rd_en) begin
            ptr_in = ptr_ff + IDX_W'(1);
         end
         if (hit) begin
            best_in     = mem_rd_ff;
            best_idx_in = rd_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
         best_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         best_ff   <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      limit_ff    <= limit_in;
      query_ff    <= query_in;
      best_idx_ff <= best_idx_in;
      rd_idx_ff   <= rd_idx_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[item_index] <= item_address;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rd_ff <= table_mem[ptr_ff];
      end
   end

   // Result register
   assign best_idx_wide = {{SYM_W{1'b0}}, best_idx_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_found_ff  <= (best_ff != '0);
         rsp_index_ff  <= (best_ff != '0) ? best_idx_wide[SYM_W-1:0] : '0;
         rsp_start_ff  <= best_ff;
         rsp_offset_ff <= (best_ff != '0) ? (query_ff - best_ff) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_symbol_index = rsp_index_ff;
   assign rsp_symbol_start = rsp_start_ff;
   assign rsp_offset       = rsp_offset_ff;

endmodule

@@ sv/nearest_symbol_lookup.sv @@
// Nearest symbol lookup: symbol start table with linear predecessor search.
//
// Request channel (req_): req_op 0 loads req_code_address into table entry
// req_entry_index (loads at or beyond the table depth are dropped); req_op 1
// looks up req_code_address. A transfer happens when req_valid is high and
// req_stall is low. Loads give no response; each query gives one response.
// Response channel (rsp_): rsp_found, rsp_symbol_index, rsp_symbol_start and
// rsp_offset, held stable while rsp_stall is high. Unknown gives all zeros.
// Register port (csr_): csr_table_count sets how many entries a query scans;
// write it only while the block is idle. It always accepts (csr_ready high).
// Scan: the table is one single-port memory read one entry a cycle, so a query
// reads min(table_count, TABLE_DEPTH) entries through the scan, last and emit
// states; an empty table goes straight to emit, and a load is written from the
// idle state. Requests reach the back end from the queue's registered slots, and
// the back end takes no new item until it is back in the idle state.
// A two-entry queue lets requests be taken while a query scans; req_stall
// rises only when it is full. A stalled response holds the back end.
// Reset clears the count register, queue and control; table contents are
// undefined until loaded, and no clearing pass is made.
module nearest_symbol_lookup
   import nsl_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [SYM_W-1:0]   req_entry_index,
   input  logic [ADDR_W-1:0]  req_code_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [SYM_W-1:0]   rsp_symbol_index,
   output logic [ADDR_W-1:0]  rsp_symbol_start,
   output logic [ADDR_W-1:0]  rsp_offset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_table_count
);

   localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned LIM_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int unsigned ITEM_W = 1 + IDX_W + ADDR_W + LIM_W;

   logic              push_valid, push_ready;
   logic [ITEM_W-1:0] push_data;
   logic              pop_valid, pop_ready;
   logic [ITEM_W-1:0] pop_data;

   nsl_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .LIM_W       (LIM_W),
      .ITEM_W      (ITEM_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_entry_index  (req_entry_index),
      .req_code_address (req_code_address),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_table_count  (csr_table_count),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   nsl_queue #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   nsl_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .LIM_W       (LIM_W),
      .ITEM_W      (ITEM_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_symbol_index (rsp_symbol_index),
      .rsp_symbol_start (rsp_symbol_start),
      .rsp_offset       (rsp_offset)
   );

   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_symbol_index == '0 && rsp_symbol_start == '0 && rsp_offset == '0))
      else $error("unknown response carries nonzero fields");

   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_symbol_start != '0))
      else $error("found response with zero symbol start");

   a_reset_quiet: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid straight after reset");

endmodule
